// File: hdl/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types, widths and helpers for the line pair intersection pipeline.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int unsigned COORD_W  = 32;  // Q-format coordinate width
  localparam int unsigned WIDE_W   = 64;  // determinant / numerator width
  localparam int unsigned QUO_W    = 31;  // unsigned quotient magnitude
  localparam int unsigned SAT_W    = 68;  // input width of the clip helper
  localparam int unsigned ERR_W    = 31;  // max_error register width
  localparam int unsigned STATUS_W = 2;

  // Stage numbers: divider runs from stage 7 to stage 38, result at 44
  localparam int unsigned DIV_IN_ST = 6;
  localparam int unsigned DIV_OUT_ST = DIV_IN_ST + QUO_W + 1;
  localparam int unsigned LAST_ST  = DIV_OUT_ST + 6;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_PARALLEL = 2'd0,
    ST_FAR      = 2'd1,
    ST_MEET     = 2'd2
  } status_e;

  // both lines of one item
  typedef struct packed {
    coord_t [2:0] p1;
    coord_t [2:0] d1;
    coord_t [2:0] p2;
    coord_t [2:0] d2;
  } geo_t;

  // per-item flags picked up along the pipe
  typedef struct packed {
    logic sat_abe;
    logic sat_cf;
    logic det_zero;
    logic neg1;
    logic neg2;
    logic sat_t;
    logic lim;
  } flags_t;

  function automatic logic over32(input logic signed [SAT_W-1:0] v);
    return !((&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1]));
  endfunction

  function automatic coord_t clip32(input logic signed [SAT_W-1:0] v);
    if (over32(v)) return v[SAT_W-1] ? COORD_MIN : COORD_MAX;
    return coord_t'(v[COORD_W-1:0]);
  endfunction

endpackage

// File: hdl/line_pair_intersection_top.sv
// ----------------------------------------------------------------------------
// line_pair_intersection_top
// Closest approach of two 3D lines in signed fixed point; reports the
// midpoint of the closest points when their gap is under max_error.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  item in   input      start / busy         first_*/second_* pos, dir
//  result    output     done_o (strobe)      status, meet_x/y/z, saturated
//  config    input      cfg_we_i             cfg_wdata_i (max_error)
//
//  One item per cycle; busy is never raised. done_o comes from the last
//  bit of the valid line, which follows the item through every stage; the
//  32-stage divider makes up most of those stages.
//  Reset clears the valid line and loads max_error with 1.0.
//  The receiver cannot stall; results leave in order, one per item.
// ----------------------------------------------------------------------------
module line_pair_intersection_top #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lpi_pkg::coord_t               first_pos_x_i,
  input  lpi_pkg::coord_t               first_pos_y_i,
  input  lpi_pkg::coord_t               first_pos_z_i,
  input  lpi_pkg::coord_t               first_dir_x_i,
  input  lpi_pkg::coord_t               first_dir_y_i,
  input  lpi_pkg::coord_t               first_dir_z_i,
  input  lpi_pkg::coord_t               second_pos_x_i,
  input  lpi_pkg::coord_t               second_pos_y_i,
  input  lpi_pkg::coord_t               second_pos_z_i,
  input  lpi_pkg::coord_t               second_dir_x_i,
  input  lpi_pkg::coord_t               second_dir_y_i,
  input  lpi_pkg::coord_t               second_dir_z_i,
  input  logic                          cfg_we_i,
  input  logic [lpi_pkg::ERR_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic [lpi_pkg::STATUS_W-1:0]  status_o,
  output lpi_pkg::coord_t               meet_x_o,
  output lpi_pkg::coord_t               meet_y_o,
  output lpi_pkg::coord_t               meet_z_o,
  output logic                          saturated_o
);
  import lpi_pkg::*;

  localparam int unsigned GeoLast = DIV_OUT_ST + 2;  // last stage needing geometry

  // ---- control and config ----
  logic [LAST_ST:0]  vld_q;      // valid bit per stage
  logic [ERR_W-1:0]  max_err_q;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      max_err_q <= ERR_W'(65536);
    end else begin
      vld_q <= {vld_q[LAST_ST-1:0], accept};
      if (cfg_we_i) begin
        max_err_q <= cfg_wdata_i;
      end
    end
  end

  // ---- geometry and flag lines, carried stage by stage ----
  geo_t   geo_q [0:GeoLast];
  flags_t flg_q [0:LAST_ST-1];
  geo_t   geo_in;

  assign geo_in.p1 = {first_pos_z_i, first_pos_y_i, first_pos_x_i};
  assign geo_in.d1 = {first_dir_z_i, first_dir_y_i, first_dir_x_i};
  assign geo_in.p2 = {second_pos_z_i, second_pos_y_i, second_pos_x_i};
  assign geo_in.d2 = {second_dir_z_i, second_dir_y_i, second_dir_x_i};

  always_ff @(posedge clk_i) begin
    geo_q[0] <= geo_in;
    for (int k = 1; k <= GeoLast; k++) begin
      geo_q[k] <= geo_q[k-1];
    end
  end

  // ---- stage 1: direction products and R = P1 - P2 ----
  logic signed [63:0] paa_q [3];
  logic signed [63:0] pab_q [3];
  logic signed [63:0] pee_q [3];
  logic signed [32:0] r_q   [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      paa_q[i] <= $signed(geo_q[0].d1[i]) * $signed(geo_q[0].d1[i]);
      pab_q[i] <= $signed(geo_q[0].d1[i]) * $signed(geo_q[0].d2[i]);
      pee_q[i] <= $signed(geo_q[0].d2[i]) * $signed(geo_q[0].d2[i]);
      r_q[i]   <= $signed({geo_q[0].p1[i][COORD_W-1], geo_q[0].p1[i]})
                - $signed({geo_q[0].p2[i][COORD_W-1], geo_q[0].p2[i]});
    end
  end

  // ---- stage 2: a, b, e sums; D.R products ----
  logic signed [SAT_W-1:0] sa_d, sb_d, se_d;
  coord_t                  a_q, b_q, e_q;
  logic signed [64:0]      pc_q [3];
  logic signed [64:0]      pf_q [3];

  always_comb begin
    sa_d = '0;
    sb_d = '0;
    se_d = '0;
    for (int i = 0; i < 3; i++) begin
      sa_d = sa_d + SAT_W'(paa_q[i] >>> COORD_FRAC_BITS);
      sb_d = sb_d + SAT_W'(pab_q[i] >>> COORD_FRAC_BITS);
      se_d = se_d + SAT_W'(pee_q[i] >>> COORD_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= clip32(sa_d);
    b_q <= clip32(sb_d);
    e_q <= clip32(se_d);
    for (int i = 0; i < 3; i++) begin
      pc_q[i] <= $signed(geo_q[1].d1[i]) * r_q[i];
      pf_q[i] <= $signed(geo_q[1].d2[i]) * r_q[i];
    end
  end

  // ---- stage 3: c, f sums ----
  logic signed [SAT_W-1:0] sc_d, sf_d;
  coord_t                  a3_q, b3_q, e3_q, c_q, f_q;

  always_comb begin
    sc_d = '0;
    sf_d = '0;
    for (int i = 0; i < 3; i++) begin
      sc_d = sc_d + SAT_W'(pc_q[i] >>> COORD_FRAC_BITS);
      sf_d = sf_d + SAT_W'(pf_q[i] >>> COORD_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    a3_q <= a_q;
    b3_q <= b_q;
    e3_q <= e_q;
    c_q  <= clip32(sc_d);
    f_q  <= clip32(sf_d);
  end

  // ---- stage 4: determinant and numerator products ----
  logic signed [63:0] ae_q, bb_q, bf_q, ce_q, af_q, cb_q;

  always_ff @(posedge clk_i) begin
    ae_q <= a3_q * e3_q;
    bb_q <= b3_q * b3_q;
    bf_q <= b3_q * f_q;
    ce_q <= c_q * e3_q;
    af_q <= a3_q * f_q;
    cb_q <= c_q * b3_q;
  end

  // ---- stage 5: det = ae - bb, n1 = bf - ce, n2 = af - cb ----
  logic signed [63:0] det_q, n1_q, n2_q;

  always_ff @(posedge clk_i) begin
    det_q <= ae_q - bb_q;
    n1_q  <= bf_q - ce_q;
    n2_q  <= af_q - cb_q;
  end

  // ---- stage 6: magnitudes into the dividers ----
  logic [WIDE_W-1:0] dmag_q, n1mag_q, n2mag_q;

  always_ff @(posedge clk_i) begin
    dmag_q  <= det_q[63] ? WIDE_W'(-det_q) : WIDE_W'(det_q);
    n1mag_q <= n1_q[63]  ? WIDE_W'(-n1_q)  : WIDE_W'(n1_q);
    n2mag_q <= n2_q[63]  ? WIDE_W'(-n2_q)  : WIDE_W'(n2_q);
  end

  // ---- stages 7..38: dividers ----
  logic [QUO_W-1:0] quo1, quo2;
  logic             ovf1, ovf2;

  lpi_div #(.FRAC(COORD_FRAC_BITS)) u_div_t1 (
    .clk_i (clk_i),
    .num_i (n1mag_q),
    .den_i (dmag_q),
    .quo_o (quo1),
    .ovf_o (ovf1)
  );

  lpi_div #(.FRAC(COORD_FRAC_BITS)) u_div_t2 (
    .clk_i (clk_i),
    .num_i (n2mag_q),
    .den_i (dmag_q),
    .quo_o (quo2),
    .ovf_o (ovf2)
  );

  // ---- stage 39: signed, clipped t1 and t2 ----
  coord_t t1_q, t2_q;
  coord_t t1_d, t2_d;
  flags_t fdiv;

  assign fdiv = flg_q[DIV_OUT_ST];

  always_comb begin
    if (ovf1) t1_d = fdiv.neg1 ? COORD_MIN : COORD_MAX;
    else      t1_d = fdiv.neg1 ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
    if (ovf2) t2_d = fdiv.neg2 ? COORD_MIN : COORD_MAX;
    else      t2_d = fdiv.neg2 ? -$signed({1'b0, quo2}) : $signed({1'b0, quo2});
  end

  always_ff @(posedge clk_i) begin
    t1_q <= t1_d;
    t2_q <= t2_d;
  end

  // ---- stage 40: D * t ----
  logic signed [63:0] pt1_q [3];
  logic signed [63:0] pt2_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pt1_q[i] <= $signed(geo_q[DIV_OUT_ST+1].d1[i]) * t1_q;
      pt2_q[i] <= $signed(geo_q[DIV_OUT_ST+1].d2[i]) * t2_q;
    end
  end

  // ---- stage 41: closest points Q1, Q2 ----
  logic signed [63:0] q1_q [3];
  logic signed [63:0] q2_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q1_q[i] <= 64'($signed(geo_q[GeoLast].p1[i])) + (pt1_q[i] >>> COORD_FRAC_BITS);
      q2_q[i] <= 64'($signed(geo_q[GeoLast].p2[i])) + (pt2_q[i] >>> COORD_FRAC_BITS);
    end
  end

  // ---- stage 42: gap magnitudes, range check, Q1 + Q2 ----
  logic signed [63:0] g_d   [3];
  logic [63:0]        gmag_d [3];
  logic               lim_d;
  logic [ERR_W-1:0]   gm_q  [3];
  logic signed [64:0] s_q   [3];

  always_comb begin
    lim_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      g_d[i]    = q1_q[i] - q2_q[i];
      gmag_d[i] = g_d[i][63] ? 64'(-g_d[i]) : 64'(g_d[i]);
      lim_d     = lim_d | (|gmag_d[i][63:31]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      gm_q[i] <= gmag_d[i][ERR_W-1:0];
      s_q[i]  <= 65'(q1_q[i]) + 65'(q2_q[i]);
    end
  end

  // ---- stage 43: squares and clipped midpoint ----
  logic [2*ERR_W-1:0] sq_q [3];
  logic [2*ERR_W-1:0] me2_q;
  coord_t             mid_q [3];
  logic               msat_q;
  logic               msat_d;

  always_comb begin
    msat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      msat_d = msat_d | over32(SAT_W'(s_q[i] >>> 1));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i]  <= gm_q[i] * gm_q[i];
      mid_q[i] <= clip32(SAT_W'(s_q[i] >>> 1));
    end
    me2_q  <= max_err_q * max_err_q;
    msat_q <= msat_d;
  end

  // ---- flag line: shift, with fields set at the stage that knows them ----
  flags_t flg_d [1:LAST_ST-1];

  always_comb begin
    for (int k = 1; k < LAST_ST; k++) begin
      flg_d[k] = flg_q[k-1];
    end
    flg_d[2].sat_abe          = over32(sa_d) | over32(sb_d) | over32(se_d);
    flg_d[3].sat_cf           = over32(sc_d) | over32(sf_d);
    flg_d[DIV_IN_ST].det_zero = (det_q == '0);
    flg_d[DIV_IN_ST].neg1     = n1_q[63] ^ det_q[63];
    flg_d[DIV_IN_ST].neg2     = n2_q[63] ^ det_q[63];
    flg_d[DIV_OUT_ST+1].sat_t = ovf1 | ovf2;
    flg_d[DIV_OUT_ST+4].lim   = lim_d;
  end

  always_ff @(posedge clk_i) begin
    flg_q[0] <= '0;
    for (int k = 1; k < LAST_ST; k++) begin
      flg_q[k] <= flg_d[k];
    end
  end

  // ---- stage 44: gap test and result ----
  logic [WIDE_W-1:0] gap2_d;
  logic              far_d;
  flags_t            fl;
  status_e           status_q;
  coord_t            mx_q, my_q, mz_q;
  logic              sat_q;

  assign fl     = flg_q[LAST_ST-1];
  assign gap2_d = WIDE_W'(sq_q[0]) + WIDE_W'(sq_q[1]) + WIDE_W'(sq_q[2]);
  assign far_d  = fl.lim || (gap2_d >= WIDE_W'(me2_q));

  always_ff @(posedge clk_i) begin
    if (fl.det_zero) begin
      status_q <= ST_PARALLEL;
      mx_q     <= '0;
      my_q     <= '0;
      mz_q     <= '0;
      sat_q    <= fl.sat_abe;
    end else if (far_d) begin
      status_q <= ST_FAR;
      mx_q     <= '0;
      my_q     <= '0;
      mz_q     <= '0;
      sat_q    <= fl.sat_abe | fl.sat_cf | fl.sat_t;
    end else begin
      status_q <= ST_MEET;
      mx_q     <= mid_q[0];
      my_q     <= mid_q[1];
      mz_q     <= mid_q[2];
      sat_q    <= fl.sat_abe | fl.sat_cf | fl.sat_t | msat_q;
    end
  end

  assign done_o      = vld_q[LAST_ST];
  assign status_o    = status_q;
  assign meet_x_o    = mx_q;
  assign meet_y_o    = my_q;
  assign meet_z_o    = mz_q;
  assign saturated_o = sat_q;

endmodule

// File: hdl/lpi_div.sv
// ----------------------------------------------------------------------------
// lpi_div
// Pipelined restoring divider: floor((num << FRAC) / den), one quotient bit
// per stage, overflow flag when the quotient does not fit QUO_W bits.
// ----------------------------------------------------------------------------
module lpi_div #(
  parameter int unsigned FRAC = 16
) (
  input  logic                        clk_i,
  input  logic [lpi_pkg::WIDE_W-1:0]  num_i,
  input  logic [lpi_pkg::WIDE_W-1:0]  den_i,
  output logic [lpi_pkg::QUO_W-1:0]   quo_o,
  output logic                        ovf_o
);
  import lpi_pkg::*;

  localparam int unsigned RemW = WIDE_W + QUO_W;

  logic [RemW-1:0]   rem_q [0:QUO_W];
  logic [WIDE_W-1:0] den_q [0:QUO_W];
  logic [QUO_W-1:0]  quo_q [0:QUO_W];
  logic              ovf_q [0:QUO_W];

  logic [RemW-1:0]   num_ext;
  logic [RemW-1:0]   sub_d [1:QUO_W];
  logic [RemW-1:0]   rem_d [1:QUO_W];
  logic              bit_d [1:QUO_W];

  assign num_ext = RemW'(num_i) << FRAC;

  always_comb begin
    for (int k = 1; k <= QUO_W; k++) begin
      sub_d[k] = RemW'(den_q[k-1]) << (QUO_W - k);
      bit_d[k] = rem_q[k-1] >= sub_d[k];
      rem_d[k] = bit_d[k] ? rem_q[k-1] - sub_d[k] : rem_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_ext;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= num_ext >= (RemW'(den_i) << QUO_W);
    for (int k = 1; k <= QUO_W; k++) begin
      rem_q[k] <= rem_d[k];
      den_q[k] <= den_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      quo_q[k] <= quo_q[k-1] | (QUO_W'(bit_d[k]) << (QUO_W - k));
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// File: hdl/lpi_chk.sv
// ----------------------------------------------------------------------------
// lpi_chk
// Port-level checks for the line pair intersection block.
// ----------------------------------------------------------------------------
module lpi_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [lpi_pkg::STATUS_W-1:0]  status_o,
  input lpi_pkg::coord_t               meet_x_o,
  input lpi_pkg::coord_t               meet_y_o,
  input lpi_pkg::coord_t               meet_z_o
);
  import lpi_pkg::*;

  // every accepted item is followed by a result on done_o
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##45 done_o)
    else $error("item without result");

  // no result that was not caused by an item
  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 45))
    else $error("result without item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_PARALLEL || status_o == ST_FAR || status_o == ST_MEET))
    else $error("bad status code");

  // no midpoint unless an intersection was found
  a_meet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_MEET) |-> (meet_x_o == '0 && meet_y_o == '0
                                         && meet_z_o == '0))
    else $error("midpoint on non-hit");

endmodule

bind line_pair_intersection_top lpi_chk u_lpi_chk (.*);
